// ----- rtl/core/jfdm_pkg.sv -----
// shared types, character codes and constants of the joystick frame drive mixer
package jfdm_pkg;

   // frame characters
   localparam logic [7:0] CH_M    = 8'h6D;
   localparam logic [7:0] CH_S    = 8'h73;
   localparam logic [7:0] CH_F    = 8'h66;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam int unsigned AXIS_W  = 17;
   localparam int unsigned COORD_W = AXIS_W + 1;
   localparam int unsigned GEAR_W  = 4;
   localparam int unsigned DUTY_W  = 16;
   localparam int unsigned PROD_W  = AXIS_W + GEAR_W;

   localparam logic [AXIS_W-1:0] CENTER_RESET   = 17'd8000;
   localparam logic [AXIS_W-1:0] DEADBAND_RESET = 17'd500;
   localparam logic [GEAR_W-1:0] GEAR_RESET     = 4'd1;

   localparam logic [2:0] DIGITS_PER_AXIS = 3'd5;

   // mixing thresholds on centred magnitudes
   localparam logic [AXIS_W-1:0] STILL_LIMIT = 17'd20;
   localparam logic [AXIS_W-1:0] ALONG_LIMIT = 17'd10;
   localparam logic [AXIS_W-1:0] SPOT_LIMIT  = 17'd10;

   // floor(n / 10) = (n * DIV10_RECIP) >> DIV10_SHIFT for every n below 2**22
   localparam logic [PROD_W-1:0] DIV10_RECIP = 21'd1677722;
   localparam int unsigned       DIV10_SHIFT = 24;
   localparam int unsigned       QUOT_W      = 2 * PROD_W - DIV10_SHIFT;

   localparam logic [DUTY_W-1:0] DUTY_MAX = 16'hFFFF;

   localparam int unsigned QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_OFFSET = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND      = 1'd1;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_GEAR = 4'd1,
      PH_SCHK = 4'd2,
      PH_XDIG = 4'd3,
      PH_FCHK = 4'd4,
      PH_YDIG = 4'd5,
      PH_TAIL = 4'd6
   } phase_type;

   // one evaluation request from the parser to the mixer
   typedef struct packed {
      logic signed [COORD_W-1:0] x_pos;
      logic signed [COORD_W-1:0] y_pos;
      logic [GEAR_W-1:0]         gear;
   } cmd_type;

   function automatic logic signed [COORD_W-1:0] center_axis(
      input logic [AXIS_W-1:0] raw,
      input logic [AXIS_W-1:0] offset,
      input logic [AXIS_W-1:0] dead);
      logic signed [COORD_W-1:0] diff;
      logic [COORD_W-1:0]        size;
      diff = signed'({1'b0, raw}) - signed'({1'b0, offset});
      size = diff[COORD_W-1] ? COORD_W'(-diff) : COORD_W'(diff);
      if (size < {1'b0, dead}) begin
         diff = '0;
      end
      return diff;
   endfunction

endpackage

// ----- rtl/core/jfdm_front.sv -----
// frame parser: takes received bytes, tracks the frame and issues mixer requests
module jfdm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   input  logic                              csr_we,
   input  logic [jfdm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jfdm_pkg::AXIS_W-1:0]       csr_wdata,
   output logic                              push_valid,
   output jfdm_pkg::cmd_type                 push_cmd,
   input  logic                              push_ready
);

   jfdm_pkg::phase_type                      phase_ff, phase_in;
   logic [2:0]                               count_ff, count_in;
   logic [jfdm_pkg::AXIS_W-1:0]              accum_ff, accum_in;
   logic                                     newx_ff, newx_in;
   logic                                     newy_ff, newy_in;
   logic [jfdm_pkg::AXIS_W-1:0]              rawx_ff, rawx_in;
   logic signed [jfdm_pkg::COORD_W-1:0]      x_ff, x_in;
   logic signed [jfdm_pkg::COORD_W-1:0]      y_ff, y_in;
   logic [jfdm_pkg::GEAR_W-1:0]              gear_ff, gear_in;
   logic [jfdm_pkg::AXIS_W-1:0]              center_ff, center_in;
   logic [jfdm_pkg::AXIS_W-1:0]              dead_ff, dead_in;

   logic                                     accept;
   logic                                     is_digit;
   logic [3:0]                               digit;
   logic [jfdm_pkg::AXIS_W+2:0]              accum_mul;
   logic [jfdm_pkg::AXIS_W-1:0]              accum_next;
   logic [2:0]                               count_next;
   logic [7:0]                               digit_wide;

   assign req_ready  = push_ready;
   assign accept     = req_valid & push_ready;
   assign is_digit   = (req_rx_byte >= jfdm_pkg::CH_ZERO) && (req_rx_byte <= jfdm_pkg::CH_NINE);
   assign digit_wide = req_rx_byte - jfdm_pkg::CH_ZERO;
   assign digit      = digit_wide[3:0];
   // accum * 10 + digit as shift and add, kept to 17 bits
   assign accum_mul  = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0}
                       + {{(jfdm_pkg::AXIS_W-1){1'b0}}, digit};
   assign accum_next = accum_mul[jfdm_pkg::AXIS_W-1:0];
   assign count_next = count_ff + 3'd1;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      accum_in   = accum_ff;
      newx_in    = newx_ff;
      newy_in    = newy_ff;
      rawx_in    = rawx_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      gear_in    = gear_ff;
      center_in  = center_ff;
      dead_in    = dead_ff;
      push_valid = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            jfdm_pkg::CSR_CENTER_OFFSET: center_in = csr_wdata;
            jfdm_pkg::CSR_DEADBAND:      dead_in   = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         unique case (phase_ff)
            jfdm_pkg::PH_GEAR: begin
               if (!is_digit) begin
                  phase_in = jfdm_pkg::PH_IDLE;
               end else begin
                  gear_in  = digit + 4'd1;
                  phase_in = jfdm_pkg::PH_SCHK;
               end
            end
            jfdm_pkg::PH_SCHK: begin
               if (req_rx_byte == jfdm_pkg::CH_S) begin
                  count_in = '0;
                  accum_in = '0;
                  phase_in = jfdm_pkg::PH_XDIG;
               end else begin
                  phase_in = jfdm_pkg::PH_FCHK;
               end
            end
            jfdm_pkg::PH_XDIG, jfdm_pkg::PH_YDIG: begin
               if (!is_digit) begin
                  // broken frame: drop the coordinates gathered so far
                  newx_in  = 1'b0;
                  newy_in  = 1'b0;
                  phase_in = jfdm_pkg::PH_IDLE;
               end else begin
                  accum_in = accum_next;
                  count_in = count_next;
                  if (count_next >= jfdm_pkg::DIGITS_PER_AXIS) begin
                     count_in = '0;
                     if (phase_ff == jfdm_pkg::PH_XDIG) begin
                        rawx_in  = accum_next;
                        newx_in  = 1'b1;
                        phase_in = jfdm_pkg::PH_FCHK;
                     end else begin
                        newy_in  = 1'b1;
                        phase_in = jfdm_pkg::PH_TAIL;
                     end
                  end
               end
            end
            jfdm_pkg::PH_FCHK: begin
               if (req_rx_byte == jfdm_pkg::CH_F) begin
                  count_in = '0;
                  accum_in = '0;
                  phase_in = jfdm_pkg::PH_YDIG;
               end else begin
                  phase_in = jfdm_pkg::PH_TAIL;
               end
            end
            jfdm_pkg::PH_TAIL: begin
               if (newx_ff) begin
                  x_in = jfdm_pkg::center_axis(rawx_ff, center_ff, dead_ff);
               end
               if (newy_ff) begin
                  y_in = jfdm_pkg::center_axis(accum_ff, center_ff, dead_ff);
               end
               newx_in    = 1'b0;
               newy_in    = 1'b0;
               phase_in   = jfdm_pkg::PH_IDLE;
               push_valid = 1'b1;
            end
            default: begin
               // waiting for frame start; stray bytes re-evaluate the current position
               if (req_rx_byte == jfdm_pkg::CH_M) begin
                  newx_in  = 1'b0;
                  newy_in  = 1'b0;
                  count_in = '0;
                  phase_in = jfdm_pkg::PH_GEAR;
               end else begin
                  phase_in   = jfdm_pkg::PH_IDLE;
                  push_valid = 1'b1;
               end
            end
         endcase
      end

      push_cmd.x_pos = x_in;
      push_cmd.y_pos = y_in;
      push_cmd.gear  = gear_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jfdm_pkg::PH_IDLE;
         count_ff  <= '0;
         accum_ff  <= '0;
         newx_ff   <= 1'b0;
         newy_ff   <= 1'b0;
         rawx_ff   <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         gear_ff   <= jfdm_pkg::GEAR_RESET;
         center_ff <= jfdm_pkg::CENTER_RESET;
         dead_ff   <= jfdm_pkg::DEADBAND_RESET;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         newx_ff   <= newx_in;
         newy_ff   <= newy_in;
         rawx_ff   <= rawx_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         gear_ff   <= gear_in;
         center_ff <= center_in;
         dead_ff   <= dead_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == jfdm_pkg::PH_GEAR || phase_ff == jfdm_pkg::PH_SCHK ||
                  phase_ff == jfdm_pkg::PH_XDIG || phase_ff == jfdm_pkg::PH_FCHK ||
                  phase_ff == jfdm_pkg::PH_YDIG)) |-> !push_valid)
      else $error("mixer request issued in the middle of a frame");
   a_digit_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < jfdm_pkg::DIGITS_PER_AXIS)
      else $error("digit count passed the field length");
`endif

endmodule

// ----- rtl/core/jfdm_queue.sv -----
// short request queue between the parser and the mixer
module jfdm_queue #(
   parameter int unsigned DEPTH = jfdm_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  jfdm_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output jfdm_pkg::cmd_type pop_cmd,
   input  logic              pop_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   jfdm_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("request pushed into a full queue");
`endif

endmodule

// ----- rtl/core/jfdm_back.sv -----
// mixer: region rules, duty scaling by gear, saturation and held outputs
module jfdm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   input  jfdm_pkg::cmd_type           pop_cmd,
   output logic                        pop_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_left_on,
   output logic                        rsp_right_on,
   output logic [jfdm_pkg::DUTY_W-1:0] rsp_left_duty,
   output logic [jfdm_pkg::DUTY_W-1:0] rsp_right_duty,
   output logic                        rsp_rule_hit
);

   localparam int unsigned AW = jfdm_pkg::AXIS_W;
   localparam int unsigned CW = jfdm_pkg::COORD_W;
   localparam int unsigned PW = jfdm_pkg::PROD_W;
   localparam int unsigned QW = jfdm_pkg::QUOT_W;

   typedef struct packed {
      logic          left_on;
      logic          right_on;
      logic          hit;
      logic [PW-1:0] prod_l;
      logic [PW-1:0] prod_r;
   } mix_type;

   // stage 1: rules and gear product
   logic                  v1_ff;
   mix_type               s1_ff, s1_in;
   logic                  ready1;
   logic                  ready2;

   logic signed [CW-1:0]  x_pos;
   logic signed [CW-1:0]  y_pos;
   logic [CW-1:0]         x_abs;
   logic [CW-1:0]         y_abs;
   logic [AW-1:0]         ax;
   logic [AW-1:0]         ay;
   logic [AW-1:0]         axy_diff;
   logic                  x_gt0, x_lt0, y_gt0, y_lt0;
   logic                  ca, cb, cp, cq;
   logic [AW-1:0]         sel_l;
   logic [AW-1:0]         sel_r;

   // stage 2: divide by ten and saturate into the output register
   logic [2*PW-1:0]                 full_l;
   logic [2*PW-1:0]                 full_r;
   logic [QW-1:0]                   quot_l;
   logic [QW-1:0]                   quot_r;
   logic [jfdm_pkg::DUTY_W-1:0]     duty_l;
   logic [jfdm_pkg::DUTY_W-1:0]     duty_r;

   logic                            rsp_valid_ff;
   logic                            left_on_ff;
   logic                            right_on_ff;
   logic [jfdm_pkg::DUTY_W-1:0]     left_duty_ff;
   logic [jfdm_pkg::DUTY_W-1:0]     right_duty_ff;
   logic                            rule_hit_ff;

   assign ready2    = !rsp_valid_ff || rsp_ready;
   assign ready1    = !v1_ff || ready2;
   assign pop_ready = ready1;

   assign x_pos    = pop_cmd.x_pos;
   assign y_pos    = pop_cmd.y_pos;
   assign x_abs    = x_pos[CW-1] ? CW'(-x_pos) : CW'(x_pos);
   assign y_abs    = y_pos[CW-1] ? CW'(-y_pos) : CW'(y_pos);
   assign ax       = x_abs[AW-1:0];
   assign ay       = y_abs[AW-1:0];
   assign axy_diff = (ax >= ay) ? ax - ay : ay - ax;
   assign x_lt0    = x_pos[CW-1];
   assign y_lt0    = y_pos[CW-1];
   assign x_gt0    = !x_pos[CW-1] && (x_pos != '0);
   assign y_gt0    = !y_pos[CW-1] && (y_pos != '0);

   function automatic logic [AW-1:0] pick(input logic c1, input logic c2,
                                          input logic [AW-1:0] mx,
                                          input logic [AW-1:0] my,
                                          input logic [AW-1:0] md);
      logic [AW-1:0] res;
      unique case ({c1, c2})
         2'b10:   res = mx;
         2'b01:   res = my;
         2'b11:   res = md;
         default: res = '0;
      endcase
      return res;
   endfunction

   always_comb begin
      s1_in.left_on  = 1'b0;
      s1_in.right_on = 1'b0;
      s1_in.hit      = 1'b1;
      ca = 1'b0; cb = 1'b0; cp = 1'b0; cq = 1'b0;
      priority if (ax < jfdm_pkg::STILL_LIMIT && ay < jfdm_pkg::STILL_LIMIT) begin
      end else if (ax < jfdm_pkg::ALONG_LIMIT && y_lt0) begin
         cb = 1'b1; cq = 1'b1;
      end else if (ax < jfdm_pkg::ALONG_LIMIT && y_gt0) begin
         s1_in.left_on = 1'b1; s1_in.right_on = 1'b1; cb = 1'b1; cq = 1'b1;
      end else if (x_lt0 && ay <= jfdm_pkg::SPOT_LIMIT) begin
         s1_in.right_on = 1'b1; ca = 1'b1; cp = 1'b1;
      end else if (x_gt0 && ay <= jfdm_pkg::SPOT_LIMIT) begin
         s1_in.left_on = 1'b1; ca = 1'b1; cp = 1'b1;
      end else if (x_gt0 && y_gt0 && ax > ay) begin
         s1_in.left_on = 1'b1; ca = 1'b1; cp = 1'b1; cq = 1'b1;
      end else if (x_gt0 && y_gt0 && ax < ay) begin
         s1_in.left_on = 1'b1; s1_in.right_on = 1'b1; cb = 1'b1; cp = 1'b1; cq = 1'b1;
      end else if (x_lt0 && y_gt0 && ax < ay) begin
         s1_in.left_on = 1'b1; s1_in.right_on = 1'b1; ca = 1'b1; cb = 1'b1; cq = 1'b1;
      end else if (x_lt0 && y_gt0) begin
         s1_in.right_on = 1'b1; ca = 1'b1; cb = 1'b1; cp = 1'b1;
      end else if (x_lt0 && y_lt0 && ax > ay) begin
         s1_in.right_on = 1'b1; ca = 1'b1; cp = 1'b1; cq = 1'b1;
      end else if (x_lt0 && y_lt0 && ax < ay) begin
         cb = 1'b1; cp = 1'b1; cq = 1'b1;
      end else if (x_gt0 && y_lt0 && ax < ay) begin
         ca = 1'b1; cb = 1'b1; cq = 1'b1;
      end else if (x_gt0 && y_lt0 && ax > ay) begin
         s1_in.left_on = 1'b1; ca = 1'b1; cb = 1'b1; cp = 1'b1;
      end else begin
         // diagonal ties match no rule, except with x negative and y positive
         s1_in.hit = 1'b0;
      end
      sel_l = pick(ca, cb, ax, ay, axy_diff);
      sel_r = pick(cp, cq, ax, ay, axy_diff);
      s1_in.prod_l = PW'(sel_l) * PW'(pop_cmd.gear);
      s1_in.prod_r = PW'(sel_r) * PW'(pop_cmd.gear);
   end

   always_ff @(posedge clock) begin
      if (ready1 && pop_valid) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= pop_valid;
      end
   end

   assign full_l = (2*PW)'(s1_ff.prod_l) * (2*PW)'(jfdm_pkg::DIV10_RECIP);
   assign full_r = (2*PW)'(s1_ff.prod_r) * (2*PW)'(jfdm_pkg::DIV10_RECIP);
   assign quot_l = full_l[2*PW-1:jfdm_pkg::DIV10_SHIFT];
   assign quot_r = full_r[2*PW-1:jfdm_pkg::DIV10_SHIFT];
   assign duty_l = (quot_l > QW'(jfdm_pkg::DUTY_MAX)) ? jfdm_pkg::DUTY_MAX
                                                       : quot_l[jfdm_pkg::DUTY_W-1:0];
   assign duty_r = (quot_r > QW'(jfdm_pkg::DUTY_MAX)) ? jfdm_pkg::DUTY_MAX
                                                       : quot_r[jfdm_pkg::DUTY_W-1:0];

   // the output word doubles as the held values when no rule matches
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         left_on_ff    <= 1'b0;
         right_on_ff   <= 1'b0;
         left_duty_ff  <= '0;
         right_duty_ff <= '0;
         rule_hit_ff   <= 1'b0;
      end else if (ready2) begin
         rsp_valid_ff <= v1_ff;
         if (v1_ff) begin
            rule_hit_ff <= s1_ff.hit;
            if (s1_ff.hit) begin
               left_on_ff    <= s1_ff.left_on;
               right_on_ff   <= s1_ff.right_on;
               left_duty_ff  <= duty_l;
               right_duty_ff <= duty_r;
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_on    = left_on_ff;
   assign rsp_right_on   = right_on_ff;
   assign rsp_left_duty  = left_duty_ff;
   assign rsp_right_duty = right_duty_ff;
   assign rsp_rule_hit   = rule_hit_ff;

`ifndef SYNTHESIS
   a_miss_has_no_drive: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !s1_ff.hit) |-> (s1_ff.prod_l == '0 && s1_ff.prod_r == '0 &&
                                 !s1_ff.left_on && !s1_ff.right_on))
      else $error("unmatched word carries drive");
   a_miss_holds_outputs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_rule_hit) |->
         $stable({rsp_left_on, rsp_right_on, rsp_left_duty, rsp_right_duty}))
      else $error("held outputs changed on an unmatched word");
`endif

endmodule

// ----- rtl/core/joystick_frame_drive_mixer_unit.sv -----
// joystick frame drive mixer: top level joining parser, queue and mixer
//
// Input channel req_*: one received serial byte per word (req_rx_byte), valid/ready.
// A frame is 'm', a gear digit, optionally 's' and five x digits, optionally 'f'
// and five y digits, then one trailing byte. The trailing byte, and every byte
// other than 'm' seen between frames, yields one rsp_* word; other bytes yield none.
// Result channel rsp_*: direction bits, two 16-bit duties and rule_hit; when no
// rule matches the previous directions and duties are repeated with rule_hit low.
// Configuration: csr_we writes csr_wdata into register csr_index at the clock
// edge (0 centre offset, 1 deadband); write only while no word is in flight.
// Throughput: one byte per cycle while the request queue has room. Each word
// passes through the request queue, then the rule and gear stage, then the
// divide-by-ten and saturation stage that loads the output register.
// When the receiver stalls, the output register and one stage keep their words
// and the queue (QUEUE_DEPTH words) absorbs further requests; req_ready drops
// only when the queue is full.
// Reset (synchronous): parser waits for 'm', gear 1, coordinates and held
// outputs zero, registers back to centre 8000 and deadband 500.
module joystick_frame_drive_mixer_unit #(
   parameter int unsigned QUEUE_DEPTH = jfdm_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_left_on,
   output logic                             rsp_right_on,
   output logic [jfdm_pkg::DUTY_W-1:0]      rsp_left_duty,
   output logic [jfdm_pkg::DUTY_W-1:0]      rsp_right_duty,
   output logic                             rsp_rule_hit,
   input  logic                             csr_we,
   input  logic [jfdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jfdm_pkg::AXIS_W-1:0]      csr_wdata
);

   logic              push_valid;
   logic              push_ready;
   jfdm_pkg::cmd_type push_cmd;
   logic              pop_valid;
   logic              pop_ready;
   jfdm_pkg::cmd_type pop_cmd;

   jfdm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .push_ready  (push_ready)
   );

   jfdm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   jfdm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_cmd        (pop_cmd),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_left_on    (rsp_left_on),
      .rsp_right_on   (rsp_right_on),
      .rsp_left_duty  (rsp_left_duty),
      .rsp_right_duty (rsp_right_duty),
      .rsp_rule_hit   (rsp_rule_hit)
   );

endmodule

// ----- verif/tb_joystick_frame_drive_mixer_unit.sv -----
// self-checking testbench for the joystick frame drive mixer unit
`timescale 1ns / 1ps

module tb_joystick_frame_drive_mixer_unit;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RAW_MAX     = 99999;
   localparam logic [7:0] CH_DOT = 8'h2E;

   typedef struct packed {
      logic                        left_on;
      logic                        right_on;
      logic [jfdm_pkg::DUTY_W-1:0] left_duty;
      logic [jfdm_pkg::DUTY_W-1:0] right_duty;
      logic                        rule_hit;
   } drive_word_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_rx_byte = '0;
   logic                             rsp_valid;
   logic                             rsp_ready   = 1'b0;
   logic                             rsp_left_on;
   logic                             rsp_right_on;
   logic [jfdm_pkg::DUTY_W-1:0]      rsp_left_duty;
   logic [jfdm_pkg::DUTY_W-1:0]      rsp_right_duty;
   logic                             rsp_rule_hit;
   logic                             csr_we      = 1'b0;
   logic [jfdm_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [jfdm_pkg::AXIS_W-1:0]      csr_wdata   = '0;

   // mirror of the parser and mixer state
   logic [jfdm_pkg::AXIS_W-1:0]         cfg_centre   = jfdm_pkg::CENTER_RESET;
   logic [jfdm_pkg::AXIS_W-1:0]         cfg_deadband = jfdm_pkg::DEADBAND_RESET;
   jfdm_pkg::phase_type                 frame_phase  = jfdm_pkg::PH_IDLE;
   logic [2:0]                          digits_seen  = '0;
   logic [jfdm_pkg::AXIS_W-1:0]         digit_value  = '0;
   bit                                  x_fresh      = 1'b0;
   bit                                  y_fresh      = 1'b0;
   logic [jfdm_pkg::AXIS_W-1:0]         x_raw_kept   = '0;
   logic signed [jfdm_pkg::COORD_W-1:0] x_pos        = '0;
   logic signed [jfdm_pkg::COORD_W-1:0] y_pos        = '0;
   logic [jfdm_pkg::GEAR_W-1:0]         gear_now     = jfdm_pkg::GEAR_RESET;
   drive_word_type                      drive_held   = '0;
   drive_word_type                      drive_words_due[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_left      = 0;
   int bytes_sent     = 0;
   int drive_faults   = 0;
   int cycle_count    = 0;

   joystick_frame_drive_mixer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_left_on    (rsp_left_on),
      .rsp_right_on   (rsp_right_on),
      .rsp_left_duty  (rsp_left_duty),
      .rsp_right_duty (rsp_right_duty),
      .rsp_rule_hit   (rsp_rule_hit),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL joystick_frame_drive_mixer_unit");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic signed [jfdm_pkg::COORD_W-1:0] centred_axis(
      input logic [jfdm_pkg::AXIS_W-1:0] raw);
      int r, c0, dead, diff;
      r    = raw;
      c0   = cfg_centre;
      dead = cfg_deadband;
      diff = r - c0;
      if ((diff < 0 ? -diff : diff) < dead) begin
         diff = 0;
      end
      return diff[jfdm_pkg::COORD_W-1:0];
   endfunction

   function automatic logic [jfdm_pkg::DUTY_W-1:0] scaled_duty(input bit c1, input bit c2,
                                                              input int ax, input int ay);
      longint d, g;
      d = 0;
      g = gear_now;
      if (c1) d += ax;
      if (c2) d -= ay;
      if (d < 0) d = -d;
      d = d * g / 10;
      if (d > 65535) d = 65535;
      return d[jfdm_pkg::DUTY_W-1:0];
   endfunction

   // rule list on the centred coordinates, first match wins
   function automatic void mix_coordinates();
      int x, y, ax, ay;
      bit dl, dr, la, lb, ra, rb, hit;
      drive_word_type word;
      x   = x_pos;
      y   = y_pos;
      ax  = x < 0 ? -x : x;
      ay  = y < 0 ? -y : y;
      hit = 1'b1;
      if (ax < 20 && ay < 20)                  {dl, dr, la, lb, ra, rb} = 6'b000000;
      else if (ax < 10 && y < 0)               {dl, dr, la, lb, ra, rb} = 6'b000101;
      else if (ax < 10 && y > 0)               {dl, dr, la, lb, ra, rb} = 6'b110101;
      else if (x < 0 && ay <= 10)              {dl, dr, la, lb, ra, rb} = 6'b011010;
      else if (x > 0 && ay <= 10)              {dl, dr, la, lb, ra, rb} = 6'b101010;
      else if (x > 0 && y > 0 && x > y)        {dl, dr, la, lb, ra, rb} = 6'b101011;
      else if (x > 0 && y > 0 && x < y)        {dl, dr, la, lb, ra, rb} = 6'b110111;
      else if (x < 0 && y > 0 && ax < y)       {dl, dr, la, lb, ra, rb} = 6'b111101;
      else if (x < 0 && y > 0 && ax >= y)      {dl, dr, la, lb, ra, rb} = 6'b011110;
      else if (x < 0 && y < 0 && ax > ay)      {dl, dr, la, lb, ra, rb} = 6'b011011;
      else if (x < 0 && y < 0 && ax < ay)      {dl, dr, la, lb, ra, rb} = 6'b000111;
      else if (x > 0 && y < 0 && ax < ay)      {dl, dr, la, lb, ra, rb} = 6'b001101;
      else if (x > 0 && y < 0 && ax > ay)      {dl, dr, la, lb, ra, rb} = 6'b101110;
      else begin
         hit = 1'b0;
         {dl, dr, la, lb, ra, rb} = 6'b000000;
      end
      if (hit) begin
         drive_held.left_on    = dl;
         drive_held.right_on   = dr;
         drive_held.left_duty  = scaled_duty(la, lb, ax, ay);
         drive_held.right_duty = scaled_duty(ra, rb, ax, ay);
      end
      word          = drive_held;
      word.rule_hit = hit;
      drive_words_due.push_back(word);
   endfunction

   function automatic void parse_and_mix(input logic [7:0] ch);
      bit is_digit;
      logic [3:0] dval;
      int acc;
      is_digit = (ch >= jfdm_pkg::CH_ZERO) && (ch <= jfdm_pkg::CH_NINE);
      dval     = 4'(ch - jfdm_pkg::CH_ZERO);
      case (frame_phase)
         jfdm_pkg::PH_GEAR: begin
            if (!is_digit) begin
               frame_phase = jfdm_pkg::PH_IDLE;
            end else begin
               gear_now    = dval + 4'd1;
               frame_phase = jfdm_pkg::PH_SCHK;
            end
         end
         jfdm_pkg::PH_SCHK: begin
            if (ch == jfdm_pkg::CH_S) begin
               digits_seen = '0;
               digit_value = '0;
               frame_phase = jfdm_pkg::PH_XDIG;
            end else begin
               frame_phase = jfdm_pkg::PH_FCHK;
            end
         end
         jfdm_pkg::PH_XDIG, jfdm_pkg::PH_YDIG: begin
            if (!is_digit) begin
               // a broken frame forgets its coordinates but keeps its gear
               x_fresh     = 1'b0;
               y_fresh     = 1'b0;
               frame_phase = jfdm_pkg::PH_IDLE;
            end else begin
               acc         = digit_value * 10 + dval;
               digit_value = acc[jfdm_pkg::AXIS_W-1:0];
               digits_seen = digits_seen + 1'b1;
               if (digits_seen >= jfdm_pkg::DIGITS_PER_AXIS) begin
                  digits_seen = '0;
                  if (frame_phase == jfdm_pkg::PH_XDIG) begin
                     x_raw_kept  = digit_value;
                     x_fresh     = 1'b1;
                     frame_phase = jfdm_pkg::PH_FCHK;
                  end else begin
                     y_fresh     = 1'b1;
                     frame_phase = jfdm_pkg::PH_TAIL;
                  end
               end
            end
         end
         jfdm_pkg::PH_FCHK: begin
            if (ch == jfdm_pkg::CH_F) begin
               digits_seen = '0;
               digit_value = '0;
               frame_phase = jfdm_pkg::PH_YDIG;
            end else begin
               frame_phase = jfdm_pkg::PH_TAIL;
            end
         end
         jfdm_pkg::PH_TAIL: begin
            if (x_fresh) x_pos = centred_axis(x_raw_kept);
            if (y_fresh) y_pos = centred_axis(digit_value);
            x_fresh     = 1'b0;
            y_fresh     = 1'b0;
            frame_phase = jfdm_pkg::PH_IDLE;
            mix_coordinates();
         end
         default: begin
            if (ch == jfdm_pkg::CH_M) begin
               x_fresh     = 1'b0;
               y_fresh     = 1'b0;
               digits_seen = '0;
               frame_phase = jfdm_pkg::PH_GEAR;
            end else begin
               // stray byte between frames re-evaluates the current position
               frame_phase = jfdm_pkg::PH_IDLE;
               mix_coordinates();
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : drive_check
      drive_word_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_left_on, rsp_right_on, rsp_left_duty, rsp_right_duty, rsp_rule_hit};
         if (drive_words_due.size() == 0) begin
            drive_faults++;
            if (drive_faults <= 10) begin
               $display("unexpected drive word: on %b/%b duty %0d/%0d hit %b",
                        got.left_on, got.right_on, got.left_duty, got.right_duty,
                        got.rule_hit);
            end
         end else begin
            want = drive_words_due.pop_front();
            if (got.left_on !== want.left_on || got.right_on !== want.right_on ||
                got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
                got.rule_hit !== want.rule_hit) begin
               drive_faults++;
               if (drive_faults <= 10) begin
                  $display("drive word mismatch: expected on %b/%b duty %0d/%0d hit %b",
                           want.left_on, want.right_on, want.left_duty, want.right_duty,
                           want.rule_hit);
                  $display("                     actual   on %b/%b duty %0d/%0d hit %b",
                           got.left_on, got.right_on, got.left_duty, got.right_duty,
                           got.rule_hit);
               end
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= ch;
      do @(posedge clock); while (!req_ready);
      parse_and_mix(ch);
      bytes_sent++;
   endtask

   task automatic send_digits(input int v);
      int div;
      div = 10000;
      repeat (5) begin
         send_byte(jfdm_pkg::CH_ZERO + 8'((v / div) % 10));
         div = div / 10;
      end
   endtask

   task automatic send_frame(input logic [7:0] gear_ch, input logic [7:0] s_ch,
                             input int x_raw, input logic [7:0] f_ch, input int y_raw,
                             input logic [7:0] tail_ch);
      send_byte(jfdm_pkg::CH_M);
      send_byte(gear_ch);
      send_byte(s_ch);
      if (s_ch == jfdm_pkg::CH_S) send_digits(x_raw);
      send_byte(f_ch);
      if (f_ch == jfdm_pkg::CH_F) send_digits(y_raw);
      send_byte(tail_ch);
   endtask

   // finish any open frame, then let every word come out
   task automatic settle();
      while (frame_phase != jfdm_pkg::PH_IDLE) send_byte(CH_DOT);
      req_valid <= 1'b0;
      while (drive_words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // strobe one register write, then drop the write enable before the next
   task automatic write_reg(input logic [jfdm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [jfdm_pkg::AXIS_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         jfdm_pkg::CSR_CENTER_OFFSET: cfg_centre = val;
         jfdm_pkg::CSR_DEADBAND:      cfg_deadband = val;
         default: ;
      endcase
   endtask

   function automatic logic [7:0] any_nondigit();
      logic [7:0] ch;
      do ch = 8'($urandom_range(255));
      while (ch >= jfdm_pkg::CH_ZERO && ch <= jfdm_pkg::CH_NINE);
      return ch;
   endfunction

   function automatic int clamp_raw(input int v);
      return v < 0 ? 0 : (v > RAW_MAX ? RAW_MAX : v);
   endfunction

   // mostly near the centre so that the narrow regions get hit
   function automatic int pick_raw();
      int c, v;
      c = cfg_centre;
      case ($urandom_range(3))
         0:       v = int'($urandom_range(RAW_MAX));
         1, 2:    v = c + int'($urandom_range(120)) - 60;
         default: v = c + int'($urandom_range(6000)) - 3000;
      endcase
      return clamp_raw(v);
   endfunction

   task automatic test_directed_frames();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(jfdm_pkg::CH_NINE, jfdm_pkg::CH_S, RAW_MAX, jfdm_pkg::CH_F, 0, 8'hFF);
      // no coordinates: check bytes skipped, old position re-mixed
      send_frame(jfdm_pkg::CH_ZERO, 8'h61, 0, 8'h71, 0, 8'h7A);
      // bad gear drops the frame
      send_byte(jfdm_pkg::CH_M);
      send_byte(jfdm_pkg::CH_S);
      // bad digit drops the frame, gear stays
      send_byte(jfdm_pkg::CH_M);
      send_byte(jfdm_pkg::CH_ZERO + 8'd5);
      send_byte(jfdm_pkg::CH_S);
      send_byte(jfdm_pkg::CH_ZERO + 8'd1);
      send_byte(jfdm_pkg::CH_ZERO + 8'd2);
      send_byte(8'h61);
      send_byte(8'h20);
      settle();
   endtask

   task automatic test_register_extremes();
      write_reg(jfdm_pkg::CSR_CENTER_OFFSET, '1);
      write_reg(jfdm_pkg::CSR_DEADBAND, '1);
      send_frame(jfdm_pkg::CH_ZERO + 8'd3, jfdm_pkg::CH_S, 0, jfdm_pkg::CH_F, RAW_MAX,
                 8'h00);
      settle();
      write_reg(jfdm_pkg::CSR_CENTER_OFFSET, '0);
      write_reg(jfdm_pkg::CSR_DEADBAND, '0);
      send_frame(jfdm_pkg::CH_ZERO, jfdm_pkg::CH_S, 0, jfdm_pkg::CH_F, RAW_MAX, CH_DOT);
      send_frame(jfdm_pkg::CH_NINE, jfdm_pkg::CH_S, RAW_MAX, jfdm_pkg::CH_F, 0,
                 jfdm_pkg::CH_M);
      // equal magnitudes match no rule
      send_frame(jfdm_pkg::CH_ZERO + 8'd4, jfdm_pkg::CH_S, 500, jfdm_pkg::CH_F, 500,
                 CH_DOT);
      settle();
      write_reg(jfdm_pkg::CSR_DEADBAND, 17'(RAW_MAX));
      send_frame(jfdm_pkg::CH_ZERO + 8'd7, jfdm_pkg::CH_S, RAW_MAX, jfdm_pkg::CH_F, 3,
                 CH_DOT);
      settle();
   endtask

   task automatic test_random_frames(input int n_bytes, input int centre, input int dead,
                                     input int idle_pct, input int stall_pct);
      int goal, roll, x, y, c;
      logic [7:0] s_ch, f_ch;
      settle();
      write_reg(jfdm_pkg::CSR_CENTER_OFFSET, centre[jfdm_pkg::AXIS_W-1:0]);
      write_reg(jfdm_pkg::CSR_DEADBAND, dead[jfdm_pkg::AXIS_W-1:0]);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      goal = bytes_sent + n_bytes;
      while (bytes_sent < goal) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            c = cfg_centre;
            x = pick_raw();
            y = pick_raw();
            if ($urandom_range(99) < 15) begin
               y = ($urandom_range(1) != 0) ? x : clamp_raw(2 * c - x);
            end
            s_ch = ($urandom_range(4) != 0) ? jfdm_pkg::CH_S : 8'($urandom_range(255));
            f_ch = ($urandom_range(4) != 0) ? jfdm_pkg::CH_F : 8'($urandom_range(255));
            send_frame(jfdm_pkg::CH_ZERO + 8'($urandom_range(9)), s_ch, x, f_ch, y,
                       8'($urandom_range(255)));
         end else if (roll < 82) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
         end else begin
            send_byte(jfdm_pkg::CH_M);
            if ($urandom_range(4) == 0) begin
               send_byte(any_nondigit());
            end else begin
               send_byte(jfdm_pkg::CH_ZERO + 8'($urandom_range(9)));
               if ($urandom_range(1) != 0) begin
                  send_byte(jfdm_pkg::CH_S);
               end else begin
                  // first f is skipped as the x check byte
                  send_byte(jfdm_pkg::CH_F);
                  send_byte(jfdm_pkg::CH_F);
               end
               repeat ($urandom_range(4)) send_byte(jfdm_pkg::CH_ZERO + 8'($urandom_range(9)));
               send_byte(any_nondigit());
            end
         end
      end
   endtask

   task automatic test_input_backpressure();
      logic [7:0] ch;
      settle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req       = 300;
      // every stray byte yields a word, so the queue fills while the receiver holds off
      repeat (40) begin
         do ch = 8'($urandom_range(255)); while (ch == jfdm_pkg::CH_M);
         send_byte(ch);
      end
      settle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_register_extremes();
      test_random_frames(300, 8000, 500, 0, 0);
      test_random_frames(300, 50000, 0, 62, 0);
      test_random_frames(300, 99999, 15, 0, 62);
      test_input_backpressure();
      test_random_frames(300, 20000, 40, 13, 13);
      settle();
      if (drive_faults == 0 && drive_words_due.size() == 0) begin
         $display("PASS joystick_frame_drive_mixer_unit");
      end else begin
         $display("FAIL joystick_frame_drive_mixer_unit");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/jfdm_pkg.sv
rtl/core/jfdm_front.sv
rtl/core/jfdm_queue.sv
rtl/core/jfdm_back.sv
rtl/core/joystick_frame_drive_mixer_unit.sv
verif/tb_joystick_frame_drive_mixer_unit.sv
